### sv/sbc_pkg.sv
// shared types, constants and functions of the systematic (12,8) block codec
// no dependencies
package sbc_pkg;

   localparam int PARITY_BITS = 4;
   localparam int DATA_BITS   = 8;
   localparam int TABLE_BITS  = DATA_BITS * PARITY_BITS;
   localparam int ADDR_BITS   = 1;

   localparam logic [TABLE_BITS-1:0] TABLE_RESET = 32'hCF65_8421;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } sbc_mode_type;

   typedef enum logic [ADDR_BITS-1:0] {
      REG_MODE  = 1'b0,
      REG_TABLE = 1'b1
   } sbc_reg_type;

   // position of a byte within an encode pair or a decode triple
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef struct packed {
      logic [1:0]           phase;
      logic [DATA_BITS-1:0] held_bits;
   } sbc_state_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] out_byte;
      logic                 corrected;
      logic                 last_out;
   } sbc_result_type;

   typedef struct packed {
      sbc_result_type [1:0] res;
      logic [1:0]           count;
      sbc_state_type        next_state;
   } sbc_step_type;

   // parity bits in row order: bit j holds p_j
   function automatic logic [PARITY_BITS-1:0] parity_acc(
      input logic [DATA_BITS-1:0]  data,
      input logic [TABLE_BITS-1:0] ptab
   );
      logic [PARITY_BITS-1:0] acc;
      acc = '0;
      for (int i = 0; i < DATA_BITS; i++) begin
         if (data[DATA_BITS-1-i]) begin
            acc = acc ^ ptab[PARITY_BITS*i +: PARITY_BITS];
         end
      end
      return acc;
   endfunction

   function automatic logic [PARITY_BITS-1:0] reverse_nib(input logic [PARITY_BITS-1:0] v);
      logic [PARITY_BITS-1:0] r;
      for (int j = 0; j < PARITY_BITS; j++) begin
         r[j] = v[PARITY_BITS-1-j];
      end
      return r;
   endfunction

   // parity nibble in stream order, p0 in the msb
   function automatic logic [PARITY_BITS-1:0] parity_nibble(
      input logic [DATA_BITS-1:0]  data,
      input logic [TABLE_BITS-1:0] ptab
   );
      return reverse_nib(parity_acc(data, ptab));
   endfunction

   // decode one codeword; returns {corrected, data byte}
   function automatic logic [DATA_BITS:0] decode_word(
      input logic [DATA_BITS+PARITY_BITS-1:0] cw,
      input logic [TABLE_BITS-1:0]            ptab
   );
      logic [DATA_BITS-1:0]   data;
      logic [PARITY_BITS-1:0] syn;
      logic [DATA_BITS-1:0]   flip;
      logic                   hit;
      data = cw[DATA_BITS+PARITY_BITS-1:PARITY_BITS];
      syn  = parity_acc(data, ptab) ^ reverse_nib(cw[PARITY_BITS-1:0]);
      flip = '0;
      hit  = 1'b0;
      // scan from the last row down so the first matching row wins
      for (int i = DATA_BITS - 1; i >= 0; i--) begin
         if (ptab[PARITY_BITS*i +: PARITY_BITS] == syn) begin
            flip = '0;
            flip[DATA_BITS-1-i] = 1'b1;
            hit = 1'b1;
         end
      end
      return {hit, data ^ flip};
   endfunction

endpackage

### sv/sbc_req_if.sv
// input byte channel of the block codec
// depends on sbc_pkg
interface sbc_req_if;
   logic                          valid;
   logic                          ready;
   logic [sbc_pkg::DATA_BITS-1:0] data_byte;
   logic                          last_in;

   modport source (output valid, output data_byte, output last_in, input ready);
   modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

### sv/sbc_rsp_if.sv
// result byte channel of the block codec
// depends on sbc_pkg
interface sbc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sbc_pkg::DATA_BITS-1:0] out_byte;
   logic                          corrected;
   logic                          last_out;

   modport source (output valid, output out_byte, output corrected, output last_out,
                   input ready);
   modport sink   (input valid, input out_byte, input corrected, input last_out,
                   output ready);
endinterface

### sv/sbc_csr_if.sv
// register write channel of the block codec
// depends on sbc_pkg
interface sbc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sbc_pkg::ADDR_BITS-1:0]  addr;
   logic [sbc_pkg::TABLE_BITS-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

### sv/sbc_core.sv
// per-byte encode/decode step: results of one input byte and the next stream state
// depends on sbc_pkg
module sbc_core (
   input  sbc_pkg::sbc_mode_type           mode,
   input  logic [sbc_pkg::TABLE_BITS-1:0]  ptab,
   input  sbc_pkg::sbc_state_type          state,
   input  logic [sbc_pkg::DATA_BITS-1:0]   data_byte,
   input  logic                            last_in,
   output sbc_pkg::sbc_step_type           step
);

   logic [sbc_pkg::PARITY_BITS-1:0] par;
   logic [sbc_pkg::DATA_BITS:0]     dec_hi;
   logic [sbc_pkg::DATA_BITS:0]     dec_lo;

   assign par    = sbc_pkg::parity_nibble(data_byte, ptab);
   assign dec_hi = sbc_pkg::decode_word({state.held_bits, data_byte[7:4]}, ptab);
   assign dec_lo = sbc_pkg::decode_word({state.held_bits[3:0], data_byte}, ptab);

   always_comb begin
      step = '0;
      step.next_state = state;
      unique case (mode)
         sbc_pkg::MODE_ENCODE: begin
            if (state.phase != sbc_pkg::PHASE_SECOND) begin
               step.res[0].out_byte = data_byte;
               step.next_state.held_bits = {4'b0000, par};
               step.next_state.phase = sbc_pkg::PHASE_SECOND;
               if (last_in) begin
                  // flush the pending parity nibble padded with zeros
                  step.res[1].out_byte = {par, 4'b0000};
                  step.count = 2'd2;
               end else begin
                  step.count = 2'd1;
               end
            end else begin
               step.res[0].out_byte = {state.held_bits[3:0], data_byte[7:4]};
               step.res[1].out_byte = {data_byte[3:0], par};
               step.count = 2'd2;
               step.next_state.held_bits = '0;
               step.next_state.phase = sbc_pkg::PHASE_FIRST;
            end
         end
         sbc_pkg::MODE_DECODE: begin
            priority if (state.phase == sbc_pkg::PHASE_SECOND) begin
               step.res[0].out_byte  = dec_hi[7:0];
               step.res[0].corrected = dec_hi[8];
               step.count = 2'd1;
               step.next_state.held_bits = {4'b0000, data_byte[3:0]};
               step.next_state.phase = sbc_pkg::PHASE_THIRD;
            end else if (state.phase == sbc_pkg::PHASE_THIRD) begin
               step.res[0].out_byte  = dec_lo[7:0];
               step.res[0].corrected = dec_lo[8];
               step.count = 2'd1;
               step.next_state.held_bits = '0;
               step.next_state.phase = sbc_pkg::PHASE_FIRST;
            end else begin
               step.count = 2'd0;
               step.next_state.held_bits = data_byte;
               step.next_state.phase = sbc_pkg::PHASE_SECOND;
            end
         end
         default: begin
            step.count = 2'd0;
         end
      endcase
      if (last_in) begin
         step.next_state = '0;
      end
      // flag the final result of this transaction
      if (step.count == 2'd2) begin
         step.res[1].last_out = 1'b1;
      end else if (step.count == 2'd1) begin
         step.res[0].last_out = 1'b1;
      end
   end

endmodule

### sv/sbc_out_buf.sv
// two-entry result register holding the results of one transaction
// depends on sbc_pkg
module sbc_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  sbc_pkg::sbc_result_type [1:0] load_res,
   input  logic [1:0]                  load_count,
   input  logic                        pop,
   output logic                        can_load,
   output logic                        head_valid,
   output sbc_pkg::sbc_result_type     head,
   output logic [1:0]                  count
);

   sbc_pkg::sbc_result_type [1:0] entry_ff;
   sbc_pkg::sbc_result_type [1:0] entry_in;
   logic [1:0]                    count_ff;
   logic [1:0]                    count_in;

   assign can_load   = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[0];
   assign count      = count_ff;

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      priority if (load) begin
         entry_in = load_res;
         count_in = load_count;
      end else if (pop) begin
         entry_in[0] = entry_ff[1];
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      entry_ff <= entry_in;
   end

endmodule

### sv/systematic_12_8_block_codec_unit.sv
// an input byte is held in the input register, its results in the result register
// throughput: one byte per cycle while results are taken; a byte with two results
//    stalls the input until the result register drains, one result per cycle
// reset: synchronous, clears stream phase, held bits and both pipeline registers;
//    mode returns to encode and the parity table to 0xCF658421
module systematic_12_8_block_codec_unit (
   input  logic      clock,
   input  logic      reset,
   sbc_req_if.sink   req_ch,
   sbc_rsp_if.source rsp_ch,
   sbc_csr_if.sink   csr_ch
);

   sbc_pkg::sbc_mode_type          mode_ff;
   logic [sbc_pkg::TABLE_BITS-1:0] ptab_ff;
   sbc_pkg::sbc_state_type         state_ff;

   logic                          in_valid_ff;
   logic [sbc_pkg::DATA_BITS-1:0] in_byte_ff;
   logic                          in_last_ff;

   sbc_pkg::sbc_step_type   step;
   sbc_pkg::sbc_result_type head;
   logic                    can_load;
   logic                    head_valid;
   logic                    move;
   logic                    pop;
   logic [1:0]              buf_count;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sbc_pkg::MODE_ENCODE;
         ptab_ff <= sbc_pkg::TABLE_RESET;
      end else if (csr_ch.valid) begin
         unique case (sbc_pkg::sbc_reg_type'(csr_ch.addr))
            sbc_pkg::REG_MODE:  mode_ff <= sbc_pkg::sbc_mode_type'(csr_ch.wdata[0]);
            sbc_pkg::REG_TABLE: ptab_ff <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // input register advances into the result register as one step
   assign pop          = rsp_ch.valid && rsp_ch.ready;
   assign move         = in_valid_ff && can_load;
   assign req_ch.ready = !in_valid_ff || can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (move) begin
            state_ff <= step.next_state;
         end
      end
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data_byte;
         in_last_ff <= req_ch.last_in;
      end
   end

   sbc_core u_core (
      .mode      (mode_ff),
      .ptab      (ptab_ff),
      .state     (state_ff),
      .data_byte (in_byte_ff),
      .last_in   (in_last_ff),
      .step      (step)
   );

   sbc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (move),
      .load_res   (step.res),
      .load_count (step.count),
      .pop        (pop),
      .can_load   (can_load),
      .head_valid (head_valid),
      .head       (head),
      .count      (buf_count)
   );

   assign rsp_ch.valid     = head_valid;
   assign rsp_ch.out_byte  = head.out_byte;
   assign rsp_ch.corrected = head.corrected;
   assign rsp_ch.last_out  = head.last_out;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      buf_count != 2'd3)
      else $error("result register holds more than two entries");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !can_load |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("stalled input transaction lost");

   a_encode_uncorrected: assert property (@(posedge clock) disable iff (reset)
      move && mode_ff == sbc_pkg::MODE_ENCODE |-> !step.res[0].corrected && !step.res[1].corrected)
      else $error("corrected flag raised in encode mode");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      move |=> state_ff.phase != 2'd3)
      else $error("stream phase left its range");

endmodule
